FILE: hw/rtl/rc5_pkg.sv
// ----------------------------------------------------------------------------
// rc5 package
// shared constants, register indexes and rotate helpers for the rc5 cipher
// ----------------------------------------------------------------------------
package rc5_pkg;

  localparam int unsigned MaxRounds   = 20;
  localparam int unsigned MaxKeyBytes = 16;
  localparam int unsigned TableDepth  = 2 * (MaxRounds + 1);
  localparam int unsigned KeyWords    = (MaxKeyBytes + 3) / 4;
  localparam int unsigned KeyPasses   = 3;
  localparam int unsigned NumStages   = MaxRounds + 2;

  localparam logic [31:0] MagicP  = 32'hB7E15163;
  localparam logic [31:0] MagicQ  = 32'h9E3779B9;
  localparam logic [4:0]  RotMask = 5'h1F;

  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 64;

  localparam logic [CfgIdxW-1:0] RegRoundCount = 8'd0;
  localparam logic [CfgIdxW-1:0] RegKeyLength  = 8'd1;
  localparam logic [CfgIdxW-1:0] RegKeyLow     = 8'd2;
  localparam logic [CfgIdxW-1:0] RegKeyHigh    = 8'd3;

  localparam logic CmdEncrypt = 1'b0;
  localparam logic CmdDecrypt = 1'b1;

  function automatic logic [31:0] rotl(input logic [31:0] x, input logic [31:0] s);
    logic [63:0] y;
    y = {x, x} << (s[4:0] & RotMask);
    return y[63:32];
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] x, input logic [31:0] s);
    logic [63:0] y;
    y = {x, x} >> (s[4:0] & RotMask);
    return y[31:0];
  endfunction

  // initial table entry P + k*Q
  function automatic logic [31:0] init_entry(input int unsigned k);
    logic [31:0] v;
    v = MagicP;
    for (int unsigned n = 0; n < k; n++) begin
      v = v + MagicQ;
    end
    return v;
  endfunction

endpackage

FILE: hw/rtl/rc5_if.sv
// ----------------------------------------------------------------------------
// rc5 channels
// valid/ready interfaces for blocks in, blocks out and configuration writes
// ----------------------------------------------------------------------------
interface rc5_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [31:0] word_a;
  logic [31:0] word_b;
  modport source (output valid, command, word_a, word_b, input ready);
  modport sink   (input valid, command, word_a, word_b, output ready);
endinterface

interface rc5_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_a;
  logic [31:0] out_b;
  modport source (output valid, out_a, out_b, input ready);
  modport sink   (input valid, out_a, out_b, output ready);
endinterface

interface rc5_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [rc5_pkg::CfgIdxW-1:0]  index;
  logic [rc5_pkg::CfgDataW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/rc5_block_cipher.sv
// Pipeline: an accepted item passes one stage per round plus a whitening stage on each
//   end, and its result is taken from the last stage register.
// Throughput: one item per cycle once the round keys are built, while the output is not stalled.
// Key expansion after reset or any register write: a load state, 3*max(2(r+1),c) steps
//   and at most one alignment step (only when c > 2(r+1)), one per cycle, input held off.
// Reset: asynchronous, clears registers to their defaults and empties the pipeline.
// ----------------------------------------------------------------------------
// rc5 block cipher
// rc5-32/r/b encrypt/decrypt with on-chip key expansion and unrolled rounds
// ----------------------------------------------------------------------------
module rc5_block_cipher (
  input  logic       clk_i,
  input  logic       rst_ni,
  rc5_in_if.sink     in_i,
  rc5_out_if.source  out_o,
  rc5_cfg_if.sink    cfg_i
);

  localparam int unsigned TD = rc5_pkg::TableDepth;
  localparam int unsigned NS = rc5_pkg::NumStages;

  typedef enum logic [1:0] {StInit, StBuild, StAlign, StReady} sched_state_e;

  sched_state_e state_q;
  logic [4:0]   rounds_q;
  logic [4:0]   keylen_q;
  logic [63:0]  key_low_q;
  logic [63:0]  key_high_q;

  logic [31:0] s_q [TD];
  logic [31:0] l_q [rc5_pkg::KeyWords];
  logic [31:0] ka_q, kb_q;
  logic [5:0]  i_q;
  logic [1:0]  j_q;
  logic [6:0]  cnt_q;

  logic cfg_wr;
  assign cfg_i.ready = 1'b1;
  assign cfg_wr = cfg_i.valid && (cfg_i.index == rc5_pkg::RegRoundCount ||
                  cfg_i.index == rc5_pkg::RegKeyLength || cfg_i.index == rc5_pkg::RegKeyLow ||
                  cfg_i.index == rc5_pkg::RegKeyHigh);

  // saturated sizes
  logic [4:0] r_use;
  logic [4:0] b_use;
  logic [5:0] t_len;
  logic [2:0] c_len;
  logic [5:0] tc_max;
  logic [6:0] n_steps;
  assign r_use   = (rounds_q > 5'(rc5_pkg::MaxRounds)) ? 5'(rc5_pkg::MaxRounds) : rounds_q;
  assign b_use   = (keylen_q > 5'(rc5_pkg::MaxKeyBytes)) ? 5'(rc5_pkg::MaxKeyBytes) : keylen_q;
  assign t_len   = {r_use, 1'b0} + 6'd2;
  assign c_len   = (b_use == 5'd0) ? 3'd1 : 3'(({1'b0, b_use} + 6'd3) >> 2);
  assign tc_max  = (t_len > 6'(c_len)) ? t_len : 6'(c_len);
  assign n_steps = {tc_max, 1'b0} + 7'(tc_max);

  // one key expansion step
  logic [31:0] na, nb;
  logic [5:0]  i_nxt;
  logic [1:0]  j_nxt;
  always_comb begin
    na    = rc5_pkg::rotl(s_q[0] + ka_q + kb_q, 32'd3);
    nb    = rc5_pkg::rotl(l_q[j_q] + na + kb_q, na + kb_q);
    i_nxt = (i_q + 6'd1 == t_len) ? 6'd0 : i_q + 6'd1;
    j_nxt = (3'(j_q) + 3'd1 == c_len) ? 2'd0 : j_q + 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StInit;
      rounds_q   <= 5'd12;
      keylen_q   <= 5'd16;
      key_low_q  <= '0;
      key_high_q <= '0;
    end else begin
      if (cfg_wr) begin
        state_q <= StInit;
        case (cfg_i.index)
          rc5_pkg::RegRoundCount: rounds_q   <= cfg_i.data[4:0];
          rc5_pkg::RegKeyLength:  keylen_q   <= cfg_i.data[4:0];
          rc5_pkg::RegKeyLow:     key_low_q  <= cfg_i.data;
          rc5_pkg::RegKeyHigh:    key_high_q <= cfg_i.data;
          default: ;
        endcase
      end else begin
        case (state_q)
          StInit:  state_q <= StBuild;
          StBuild: if (cnt_q + 7'd1 == n_steps) begin
            state_q <= (i_nxt == 6'd0) ? StReady : StAlign;
          end
          StAlign: if (i_nxt == 6'd0) begin
            state_q <= StReady;
          end
          StReady: ;
          default: state_q <= StInit;
        endcase
      end
    end
  end

  // round key table as a rotating line: head at s_q[0], wrap at t-1
  always_ff @(posedge clk_i) begin
    case (state_q)
      StInit: begin
        for (int unsigned k = 0; k < TD; k++) begin
          s_q[k] <= rc5_pkg::init_entry(k);
        end
        for (int unsigned w = 0; w < rc5_pkg::KeyWords; w++) begin
          for (int unsigned m = 0; m < 4; m++) begin
            if (5'(4 * w + m) < b_use) begin
              l_q[w][8*m +: 8] <= (4 * w + m < 8) ? key_low_q[8*((4*w+m)%8) +: 8]
                                                  : key_high_q[8*((4*w+m)%8) +: 8];
            end else begin
              l_q[w][8*m +: 8] <= 8'd0;
            end
          end
        end
        ka_q  <= '0;
        kb_q  <= '0;
        i_q   <= '0;
        j_q   <= '0;
        cnt_q <= '0;
      end
      StBuild, StAlign: begin
        for (int unsigned k = 0; k < TD; k++) begin
          if (6'(k) == t_len - 6'd1) begin
            s_q[k] <= (state_q == StBuild) ? na : s_q[0];
          end else if (k + 1 < TD) begin
            s_q[k] <= s_q[(k + 1) % TD];
          end
        end
        i_q <= i_nxt;
        if (state_q == StBuild) begin
          ka_q     <= na;
          kb_q     <= nb;
          l_q[j_q] <= nb;
          j_q      <= j_nxt;
          cnt_q    <= cnt_q + 7'd1;
        end
      end
      default: ;
    endcase
  end

  // round pipeline
  logic        en;
  logic        vld_q [NS];
  logic        cmd_q [NS];
  logic [31:0] a_q   [NS];
  logic [31:0] b_q   [NS];

  assign en          = !vld_q[NS-1] || out_o.ready;
  assign in_i.ready  = en && (state_q == StReady);
  assign out_o.valid = vld_q[NS-1];
  assign out_o.out_a = a_q[NS-1];
  assign out_o.out_b = b_q[NS-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned p = 0; p < NS; p++) begin
        vld_q[p] <= 1'b0;
      end
    end else if (en) begin
      vld_q[0] <= in_i.valid && in_i.ready;
      for (int unsigned p = 1; p < NS; p++) begin
        vld_q[p] <= vld_q[p-1];
      end
    end
  end

  // encrypt whitening on entry
  always_ff @(posedge clk_i) begin
    if (en) begin
      cmd_q[0] <= in_i.command;
      a_q[0]   <= (in_i.command == rc5_pkg::CmdEncrypt) ? in_i.word_a + s_q[0] : in_i.word_a;
      b_q[0]   <= (in_i.command == rc5_pkg::CmdEncrypt) ? in_i.word_b + s_q[1] : in_i.word_b;
    end
  end

  for (genvar p = 1; p <= rc5_pkg::MaxRounds; p++) begin : g_round
    localparam int unsigned KD = rc5_pkg::MaxRounds + 1 - p;
    logic [31:0] ea, eb, da, db;
    always_comb begin
      ea = rc5_pkg::rotl(a_q[p-1] ^ b_q[p-1], b_q[p-1]) + s_q[2*p];
      eb = rc5_pkg::rotl(b_q[p-1] ^ ea, ea) + s_q[2*p+1];
      db = rc5_pkg::rotr(b_q[p-1] - s_q[2*KD+1], a_q[p-1]) ^ a_q[p-1];
      da = rc5_pkg::rotr(a_q[p-1] - s_q[2*KD], db) ^ db;
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        cmd_q[p] <= cmd_q[p-1];
        if (cmd_q[p-1] == rc5_pkg::CmdEncrypt && 5'(p) <= r_use) begin
          a_q[p] <= ea;
          b_q[p] <= eb;
        end else if (cmd_q[p-1] == rc5_pkg::CmdDecrypt && 5'(KD) <= r_use) begin
          a_q[p] <= da;
          b_q[p] <= db;
        end else begin
          a_q[p] <= a_q[p-1];
          b_q[p] <= b_q[p-1];
        end
      end
    end
  end

  // decrypt whitening on exit
  always_ff @(posedge clk_i) begin
    if (en) begin
      cmd_q[NS-1] <= cmd_q[NS-2];
      a_q[NS-1]   <= (cmd_q[NS-2] == rc5_pkg::CmdDecrypt) ? a_q[NS-2] - s_q[0] : a_q[NS-2];
      b_q[NS-1]   <= (cmd_q[NS-2] == rc5_pkg::CmdDecrypt) ? b_q[NS-2] - s_q[1] : b_q[NS-2];
    end
  end

  a_accept_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |-> state_q == StReady)
    else $error("item accepted before round keys were built");

  a_cfg_rebuild: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_wr |=> state_q == StInit)
    else $error("register write did not restart key expansion");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[NS-1] && !out_o.ready) |=> (vld_q[NS-1] && $stable(a_q[NS-1])))
    else $error("stalled result lost");

endmodule

FILE: dv/rc5_block_cipher_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rc5 block cipher testbench
// drives blocks through the cipher under several key and round settings and
// checks every result against a behavioral rc5 key expansion and round model
// ----------------------------------------------------------------------------
module rc5_block_cipher_tb;

  typedef struct packed {
    logic        command;
    logic [31:0] word_a;
    logic [31:0] word_b;
  } block_t;

  typedef struct packed {
    logic [31:0] out_a;
    logic [31:0] out_b;
  } cipher_t;

  // directed row: expected result only where known at a glance
  typedef struct {
    block_t      blk;
    logic        known;
    logic [31:0] exp_a;
    logic [31:0] exp_b;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  rc5_in_if  in_if ();
  rc5_out_if out_if ();
  rc5_cfg_if cfg_if ();

  rc5_block_cipher dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if.sink),
    .out_o  (out_if.source),
    .cfg_i  (cfg_if.sink)
  );

  always #1 clk_i = ~clk_i;

  // model copy of the registers and round keys
  logic [4:0]  rounds_reg;
  logic [4:0]  keylen_reg;
  logic [63:0] key_lo_reg;
  logic [63:0] key_hi_reg;
  logic [31:0] skey [rc5_pkg::TableDepth];
  logic        skey_valid;

  cipher_t     expected_q[$];
  int          errors;
  int          cycles;
  logic        quiet;
  logic        pipe_stop;

  function automatic logic [31:0] rol32(logic [31:0] x, logic [31:0] s);
    int unsigned n;
    n = 32'(s[4:0]);
    return (n == 0) ? x : ((x << n) | (x >> (32 - n)));
  endfunction

  function automatic logic [31:0] ror32(logic [31:0] x, logic [31:0] s);
    int unsigned n;
    n = 32'(s[4:0]);
    return (n == 0) ? x : ((x >> n) | (x << (32 - n)));
  endfunction

  function automatic int unsigned rounds_eff();
    return (rounds_reg > 5'(rc5_pkg::MaxRounds)) ? rc5_pkg::MaxRounds : 32'(rounds_reg);
  endfunction

  task automatic expand_key();
    int unsigned r, t, nb, c, n, i, j;
    logic [31:0] l [rc5_pkg::KeyWords];
    logic [31:0] a, b;
    logic [7:0]  byt;
    r = rounds_eff();
    t = 2 * (r + 1);
    nb = (keylen_reg > 5'(rc5_pkg::MaxKeyBytes)) ? rc5_pkg::MaxKeyBytes : 32'(keylen_reg);
    c = (nb + 3) / 4;
    if (c == 0) c = 1;
    skey[0] = rc5_pkg::MagicP;
    for (int k = 1; k < t; k++) skey[k] = skey[k-1] + rc5_pkg::MagicQ;
    for (int k = 0; k < rc5_pkg::KeyWords; k++) l[k] = '0;
    for (int k = 0; k < nb; k++) begin
      byt = (k < 8) ? key_lo_reg[8*(k%8) +: 8] : key_hi_reg[8*(k%8) +: 8];
      l[k/4][8*(k%4) +: 8] = byt;
    end
    n = rc5_pkg::KeyPasses * ((t > c) ? t : c);
    i = 0; j = 0; a = '0; b = '0;
    for (int k = 0; k < n; k++) begin
      a = rol32(skey[i] + a + b, 3);
      skey[i] = a;
      b = rol32(l[j] + a + b, a + b);
      l[j] = b;
      i = (i + 1 == t) ? 0 : i + 1;
      j = (j + 1 == c) ? 0 : j + 1;
    end
    skey_valid = 1'b1;
  endtask

  task automatic predict_block(input block_t blk, output cipher_t res);
    logic [31:0] a, b;
    int unsigned r;
    if (!skey_valid) expand_key();
    r = rounds_eff();
    a = blk.word_a;
    b = blk.word_b;
    if (blk.command == rc5_pkg::CmdEncrypt) begin
      a += skey[0];
      b += skey[1];
      for (int k = 1; k <= r; k++) begin
        a = rol32(a ^ b, b) + skey[2*k];
        b = rol32(b ^ a, a) + skey[2*k+1];
      end
    end else begin
      for (int k = r; k >= 1; k--) begin
        b = ror32(b - skey[2*k+1], a) ^ a;
        a = ror32(a - skey[2*k], b) ^ b;
      end
      b -= skey[1];
      a -= skey[0];
    end
    res.out_a = a;
    res.out_b = b;
  endtask

  function automatic logic idle_now();
    return !quiet && ($urandom_range(99) < 8);
  endfunction

  task automatic write_reg(input logic [rc5_pkg::CfgIdxW-1:0] idx, input logic [63:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    case (idx)
      rc5_pkg::RegRoundCount: rounds_reg = val[4:0];
      rc5_pkg::RegKeyLength:  keylen_reg = val[4:0];
      rc5_pkg::RegKeyLow:     key_lo_reg = val;
      rc5_pkg::RegKeyHigh:    key_hi_reg = val;
      default: ;
    endcase
    if (idx <= rc5_pkg::RegKeyHigh) skey_valid = 1'b0;
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  // sends one block, prediction taken at acceptance; valid stays up for the next one
  task automatic send_block(input block_t blk, input logic known,
                            input logic [31:0] ea, input logic [31:0] eb);
    cipher_t res;
    while (idle_now()) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.command <= blk.command;
    in_if.word_a  <= blk.word_a;
    in_if.word_b  <= blk.word_b;
    do @(posedge clk_i); while (!in_if.ready);
    predict_block(blk, res);
    if (known && (res.out_a != ea || res.out_b != eb)) begin
      $error("table row disagrees with model: out_a %h out_b %h", res.out_a, res.out_b);
      errors++;
    end
    if (known) begin
      res.out_a = ea;
      res.out_b = eb;
    end
    expected_q = {expected_q, res};
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (30) @(negedge clk_i);
  endtask

  function automatic block_t rand_block();
    block_t blk;
    blk.command = 1'($urandom_range(1));
    blk.word_a = $urandom();
    blk.word_b = $urandom();
    return blk;
  endfunction

  // result checker
  always @(posedge clk_i) begin
    cipher_t exp_res;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_q.size() == 0) begin
        $error("unexpected item: out_a %h out_b %h", out_if.out_a, out_if.out_b);
        errors++;
      end else begin
        exp_res = expected_q.pop_front();
        if (out_if.out_a !== exp_res.out_a) begin
          $error("out_a expected %h actual %h", exp_res.out_a, out_if.out_a);
          errors++;
        end
        if (out_if.out_b !== exp_res.out_b) begin
          $error("out_b expected %h actual %h", exp_res.out_b, out_if.out_b);
          errors++;
        end
      end
    end
  end

  always @(negedge clk_i) begin
    out_if.ready <= pipe_stop ? 1'b0 : !idle_now();
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > 400000) begin
      $display("rc5_block_cipher test failed");
      $finish;
    end
  end

  row_t rows [4];

  initial begin
    block_t blk;
    errors = 0;
    cycles = 0;
    quiet = 1'b0;
    pipe_stop = 1'b0;
    in_if.valid = 1'b0;
    in_if.command = rc5_pkg::CmdEncrypt;
    in_if.word_a = '0;
    in_if.word_b = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    rounds_reg = 5'd12;
    keylen_reg = 5'd16;
    key_lo_reg = '0;
    key_hi_reg = '0;
    skey_valid = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: reset defaults, zero rounds, empty key, saturation
    // rc5-32/12/16 all-zero key and block published vector
    rows[0] = '{'{rc5_pkg::CmdEncrypt, 32'h0, 32'h0}, 1'b1, 32'hEEDBA521, 32'h6D8F4B15};
    rows[1] = '{'{rc5_pkg::CmdDecrypt, 32'hEEDBA521, 32'h6D8F4B15}, 1'b1, 32'h0, 32'h0};
    rows[2] = '{'{rc5_pkg::CmdEncrypt, 32'hFFFFFFFF, 32'hFFFFFFFF}, 1'b0, '0, '0};
    rows[3] = '{'{rc5_pkg::CmdDecrypt, 32'hFFFFFFFF, 32'h00000000}, 1'b0, '0, '0};
    foreach (rows[k]) send_block(rows[k].blk, rows[k].known, rows[k].exp_a, rows[k].exp_b);
    drain();

    // zero rounds, empty key: whitening only
    write_reg(rc5_pkg::RegRoundCount, 64'd0);
    write_reg(rc5_pkg::RegKeyLength, 64'd0);
    for (int k = 0; k < 4; k++) send_block(rand_block(), 1'b0, '0, '0);
    drain();
    // above the limits: saturate, upper bits of register ignored
    write_reg(rc5_pkg::RegRoundCount, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(rc5_pkg::RegKeyLength, 64'd31);
    write_reg(rc5_pkg::RegKeyLow, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(rc5_pkg::RegKeyHigh, 64'hFFFF_FFFF_FFFF_FFFF);
    for (int k = 0; k < 4; k++) send_block(rand_block(), 1'b0, '0, '0);
    drain();
    // out-of-range index does nothing; same-value write forces rebuild
    write_reg(8'hFF, 64'h1234);
    write_reg(rc5_pkg::RegRoundCount, 64'd31);
    for (int k = 0; k < 4; k++) send_block(rand_block(), 1'b0, '0, '0);
    drain();

    // random phases
    for (int ph = 0; ph < 12; ph++) begin
      drain();
      write_reg(rc5_pkg::RegRoundCount, (ph % 4 == 0) ? 64'd1 : 64'($urandom_range(24)));
      write_reg(rc5_pkg::RegKeyLength, 64'($urandom_range(17)));
      write_reg(rc5_pkg::RegKeyLow, {$urandom(), $urandom()});
      write_reg(rc5_pkg::RegKeyHigh, {$urandom(), $urandom()});
      quiet = (ph == 5);
      for (int k = 0; k < 75; k++) begin
        blk = rand_block();
        if (k % 9 == 0) blk.word_a = (k % 2) ? '0 : '1;
        send_block(blk, 1'b0, '0, '0);
      end
      quiet = 1'b0;
    end
    drain();

    if (errors == 0 && expected_q.size() == 0) begin
      $display("rc5_block_cipher test passed");
    end else begin
      $display("rc5_block_cipher test failed");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/rc5_pkg.sv
hw/rtl/rc5_if.sv
hw/rtl/rc5_block_cipher.sv
dv/rc5_block_cipher_tb.sv
